// File: rtl/core/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes and default sizes shared by the Q24.8 arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fpalu_pkg;

  localparam int FracBitsDef  = 8;
  localparam int WordWidthDef = 32;

  typedef enum logic [3:0] {
    MODE_ADD     = 4'd0,
    MODE_SUB     = 4'd1,
    MODE_MUL     = 4'd2,
    MODE_DIV     = 4'd3,
    MODE_GT      = 4'd4,
    MODE_LT      = 4'd5,
    MODE_GE      = 4'd6,
    MODE_LE      = 4'd7,
    MODE_EQ      = 4'd8,
    MODE_NE      = 4'd9,
    MODE_MIN     = 4'd10,
    MODE_MAX     = 4'd11,
    MODE_INC     = 4'd12,
    MODE_DEC     = 4'd13,
    MODE_INTPART = 4'd14
  } mode_e;

endpackage

`default_nettype wire

// File: rtl/core/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU, Q24.8
// Pipelined arithmetic unit on signed fixed-point words with a radix-2
// restoring divider unrolled into one register stage per quotient bit.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+--------------------------
//   input    | in        | in_valid_i/in_ready_o  | mode, operand_a, operand_b
//   output   | out       | out_valid_o/out_ready_i| result_value, compare_true,
//            |           |                        | divide_by_zero
//
// One item enters per cycle while the output is not stalled or the first
// stage is empty. The divider resolves one quotient bit per stage; every mode
// travels the same stages so results leave in order.
// Reset clears all valid bits. When the output register holds a result that
// is not taken, the whole pipeline holds, and the first stage still accepts
// a transfer if it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS  = fpalu_pkg::FracBitsDef,
  parameter int WORD_WIDTH = fpalu_pkg::WordWidthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [3:0]                   mode_i,
  input  wire logic signed [WORD_WIDTH-1:0] operand_a_i,
  input  wire logic signed [WORD_WIDTH-1:0] operand_b_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic signed [WORD_WIDTH-1:0] result_value_o,
  output      logic                         compare_true_o,
  output      logic                         divide_by_zero_o
);

  localparam int W = WORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int Q = WORD_WIDTH + FRAC_BITS;

  typedef struct packed {
    logic [W-1:0] res;
    logic         cmp;
    logic         dz;
    logic         is_div;
    logic         neg;
    logic [W-1:0] dvsr;
    logic [W-1:0] rem;
    logic [Q-1:0] nq;
  } stage_t;

  stage_t       stage_q [0:Q];
  stage_t       prep_d;
  logic [Q:0]   valid_q;
  logic         adv;

  logic                     out_valid_q;
  logic [W-1:0]             result_q;
  logic                     cmp_q;
  logic                     dz_q;
  logic [W-1:0]             quot;
  logic [W-1:0]             div_res;
  logic [W-1:0]             result_d;

  logic signed [2*W-1:0]    a_ext;
  logic signed [2*W-1:0]    b_ext;
  logic signed [2*W-1:0]    prod;
  logic [W-1:0]             a_mag;
  logic [W-1:0]             b_mag;
  logic                     a_lt_b;
  logic                     b_lt_a;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv || !valid_q[0];

  assign a_ext  = {{W{operand_a_i[W-1]}}, operand_a_i};
  assign b_ext  = {{W{operand_b_i[W-1]}}, operand_b_i};
  assign prod   = a_ext * b_ext;
  assign a_mag  = operand_a_i[W-1] ? (W'(0) - operand_a_i) : operand_a_i;
  assign b_mag  = operand_b_i[W-1] ? (W'(0) - operand_b_i) : operand_b_i;
  assign a_lt_b = operand_a_i < operand_b_i;
  assign b_lt_a = operand_b_i < operand_a_i;

  always_comb begin
    prep_d        = '0;
    prep_d.dvsr   = b_mag;
    prep_d.neg    = operand_a_i[W-1] ^ operand_b_i[W-1];
    prep_d.nq     = {a_mag, {F{1'b0}}};
    unique case (fpalu_pkg::mode_e'(mode_i))
      fpalu_pkg::MODE_ADD:     prep_d.res = operand_a_i + operand_b_i;
      fpalu_pkg::MODE_SUB:     prep_d.res = operand_a_i - operand_b_i;
      fpalu_pkg::MODE_MUL:     prep_d.res = prod[F+W-1:F];
      fpalu_pkg::MODE_DIV: begin
        prep_d.is_div = 1'b1;
        prep_d.dz     = (operand_b_i == '0);
      end
      fpalu_pkg::MODE_GT:      prep_d.cmp = b_lt_a;
      fpalu_pkg::MODE_LT:      prep_d.cmp = a_lt_b;
      fpalu_pkg::MODE_GE:      prep_d.cmp = !a_lt_b;
      fpalu_pkg::MODE_LE:      prep_d.cmp = !b_lt_a;
      fpalu_pkg::MODE_EQ:      prep_d.cmp = (operand_a_i == operand_b_i);
      fpalu_pkg::MODE_NE:      prep_d.cmp = (operand_a_i != operand_b_i);
      fpalu_pkg::MODE_MIN:     prep_d.res = a_lt_b ? operand_a_i : operand_b_i;
      fpalu_pkg::MODE_MAX:     prep_d.res = b_lt_a ? operand_a_i : operand_b_i;
      fpalu_pkg::MODE_INC:     prep_d.res = operand_a_i + W'(1);
      fpalu_pkg::MODE_DEC:     prep_d.res = operand_a_i - W'(1);
      fpalu_pkg::MODE_INTPART: prep_d.res = operand_a_i >>> F;
      default:                 prep_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      stage_q[0] <= prep_d;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_div
    logic [W:0]   r2;
    logic [W+1:0] diff;
    logic         ge;
    stage_t       nxt;

    assign r2   = {stage_q[k].rem, stage_q[k].nq[Q-1]};
    assign diff = {1'b0, r2} - {2'b00, stage_q[k].dvsr};
    assign ge   = !diff[W+1];

    always_comb begin
      nxt     = stage_q[k];
      nxt.rem = ge ? diff[W-1:0] : r2[W-1:0];
      nxt.nq  = {stage_q[k].nq[Q-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stage_q[k+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q[0] <= in_valid_i;
      end
      if (adv) begin
        valid_q[Q:1] <= valid_q[Q-1:0];
        out_valid_q  <= valid_q[Q];
      end
    end
  end

  assign quot    = stage_q[Q].nq[W-1:0];
  assign div_res = stage_q[Q].neg ? (W'(0) - quot) : quot;

  always_comb begin
    result_d = stage_q[Q].res;
    if (stage_q[Q].is_div) begin
      result_d = stage_q[Q].dz ? '0 : div_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= result_d;
      cmp_q    <= stage_q[Q].cmp;
      dz_q     <= stage_q[Q].dz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = result_q;
  assign compare_true_o   = cmp_q;
  assign divide_by_zero_o = dz_q;

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(compare_true_o && divide_by_zero_o))
    else $error("Compare and divide-by-zero flags are both set.");

  a_dz_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_by_zero_o) |-> (result_value_o == '0))
    else $error("Divide by zero returned a nonzero result.");

  a_cmp_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && compare_true_o) |-> (result_value_o == '0))
    else $error("Comparison returned a nonzero result.");

  a_stall_holds_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(valid_q[Q:1]))
    else $error("Pipeline moved while the output was stalled.");
`endif

endmodule

`default_nettype wire

// File: tb/tb_fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU testbench
// Sends a directed table of edge cases and then random operations through the
// input channel. Each transfer's result is predicted here and compared field
// by field, in order, with what leaves the output channel. Both channels idle
// at random. One long output stall fills the pipeline and backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_point_alu_q24_8;

  localparam int FracBits       = fpalu_pkg::FracBitsDef;
  localparam int WordW          = fpalu_pkg::WordWidthDef;
  localparam logic [3:0] ModeUndef = 4'd15;
  localparam int RandomItems    = 500;
  localparam int CalmItems      = 100;
  localparam int PressureAt     = 180;
  localparam int PressureCycles = 300;
  localparam int DrainCycles    = 60;
  localparam int WatchdogLimit  = 2000;
  localparam int MaxPrinted     = 50;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic             cmp;
    logic             dz;
  } alu_result_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic             typed;
    logic [WordW-1:0] value;
    logic             cmp;
    logic             dz;
  } alu_stim_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [3:0]       mode = '0;
  logic [WordW-1:0] operand_a = '0;
  logic [WordW-1:0] operand_b = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [WordW-1:0] result_value;
  logic             compare_true;
  logic             divide_by_zero;

  alu_stim_t   directed_rows[$];
  alu_result_t expected_q[$];
  alu_result_t got_exp;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          pressure_req = 1'b0;
  bit          mode_seen[16];

  always #5 clk = ~clk;

  fixed_point_alu_q24_8 dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .operand_a_i     (operand_a),
    .operand_b_i     (operand_b),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_value_o  (result_value),
    .compare_true_o  (compare_true),
    .divide_by_zero_o(divide_by_zero)
  );

  function automatic alu_result_t predict_alu(input logic [3:0] m, input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    alu_result_t        r;
    logic signed [WordW-1:0] sa;
    logic signed [WordW-1:0] sb;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] wide;
    logic [63:0]        mag_n;
    logic [63:0]        mag_d;
    logic [63:0]        quo;
    r  = '0;
    sa = a;
    sb = b;
    wa = sa;
    wb = sb;
    case (m)
      fpalu_pkg::MODE_ADD: r.value = sa + sb;
      fpalu_pkg::MODE_SUB: r.value = sa - sb;
      fpalu_pkg::MODE_MUL: begin
        wide    = wa * wb;
        wide    = wide >>> FracBits;
        r.value = wide[WordW-1:0];
      end
      fpalu_pkg::MODE_DIV: begin
        if (sb == 0) begin
          r.dz = 1'b1;
        end else begin
          wide  = wa <<< FracBits;
          mag_n = wide[63] ? 64'd0 - wide : wide;
          mag_d = wb[63] ? 64'd0 - wb : wb;
          quo   = mag_n / mag_d;
          if (wide[63] ^ wb[63]) quo = 64'd0 - quo;
          r.value = quo[WordW-1:0];
        end
      end
      fpalu_pkg::MODE_GT:      r.cmp = sa > sb;
      fpalu_pkg::MODE_LT:      r.cmp = sa < sb;
      fpalu_pkg::MODE_GE:      r.cmp = sa >= sb;
      fpalu_pkg::MODE_LE:      r.cmp = sa <= sb;
      fpalu_pkg::MODE_EQ:      r.cmp = sa == sb;
      fpalu_pkg::MODE_NE:      r.cmp = sa != sb;
      fpalu_pkg::MODE_MIN:     r.value = (sa < sb) ? sa : sb;
      fpalu_pkg::MODE_MAX:     r.value = (sb < sa) ? sa : sb;
      fpalu_pkg::MODE_INC:     r.value = sa + 1;
      fpalu_pkg::MODE_DEC:     r.value = sa - 1;
      fpalu_pkg::MODE_INTPART: r.value = sa >>> FracBits;
      default:                 r = '0;
    endcase
    return r;
  endfunction

  task automatic add_row(input logic [3:0] m, input logic [WordW-1:0] a,
                         input logic [WordW-1:0] b, input logic typed,
                         input logic [WordW-1:0] v, input logic c, input logic z);
    alu_stim_t row;
    row.mode  = m;
    row.a     = a;
    row.b     = b;
    row.typed = typed;
    row.value = v;
    row.cmp   = c;
    row.dz    = z;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed_rows();
    add_row(fpalu_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_MUL, 32'h0000_0100, 32'h0000_0100, 1'b1, 32'h0000_0100, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_DIV, 32'h0000_0100, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
    add_row(fpalu_pkg::MODE_DIV, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
    add_row(fpalu_pkg::MODE_DIV, 32'h0000_0300, 32'h0000_0200, 1'b1, 32'h0000_0180, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_DIV, 32'hFFFF_FD00, 32'h0000_0200, 1'b0, '0, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_DIV, 32'hFFFF_FFFF, 32'h0000_0300, 1'b0, '0, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, '0, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_GT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
    add_row(fpalu_pkg::MODE_LT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
    add_row(fpalu_pkg::MODE_GE, 32'h1234_5678, 32'h1234_5678, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
    add_row(fpalu_pkg::MODE_LE, 32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_EQ, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
    add_row(fpalu_pkg::MODE_NE, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_DEC, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_INTPART, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
            32'h007F_FFFF, 1'b0, 1'b0);
    add_row(fpalu_pkg::MODE_INTPART, 32'hFFFF_FF00, 32'h7FFF_FFFF, 1'b1,
            32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(ModeUndef, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0);
  endtask

  function automatic logic [WordW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return $urandom_range(0, 1023) << FracBits;
      4:       return 32'h0 - $urandom_range(1, 4095);
      5:       return $urandom_range(1, 4095);
      default: return $urandom();
    endcase
  endfunction

  function automatic alu_stim_t random_item();
    alu_stim_t item;
    item       = '0;
    item.mode  = ($urandom_range(0, 31) == 0) ? ModeUndef : 4'($urandom_range(0, 14));
    item.a     = pick_operand();
    item.b     = ($urandom_range(0, 4) == 0) ? item.a : pick_operand();
    item.typed = 1'b0;
    return item;
  endfunction

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("%0t: result %0d %s got %h expected %h", $realtime, results_seen, what, got,
               want);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("arrived with nothing outstanding", result_value, '0);
      end else begin
        got_exp = expected_q.pop_front();
        if (result_value !== got_exp.value) begin
          report_mismatch("result_value", result_value, got_exp.value);
        end
        if (compare_true !== got_exp.cmp) begin
          report_mismatch("compare_true", 32'(compare_true), 32'(got_exp.cmp));
        end
        if (divide_by_zero !== got_exp.dz) begin
          report_mismatch("divide_by_zero", 32'(divide_by_zero), 32'(got_exp.dz));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout after %0d cycles without a transfer.", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : receiver
    int hold_cnt;
    bit pressure_done;
    pressure_done = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (pressure_req && !pressure_done) begin
        out_ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < PressureCycles) begin
          @(negedge clk);
          hold_cnt++;
        end
        pressure_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    alu_stim_t   item;
    alu_result_t pending;
    int          n_total;
    int          n_sent;
    int          n_modes;
    build_directed_rows();
    n_sent  = 0;
    n_modes = 0;
    n_total = directed_rows.size() + RandomItems;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    for (int idx = 0; idx < n_total; idx++) begin
      item = (idx < directed_rows.size()) ? directed_rows[idx] : random_item();
      calm = (idx >= n_total - CalmItems);
      if (idx == PressureAt) pressure_req = 1'b1;
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      mode      <= item.mode;
      operand_a <= item.a;
      operand_b <= item.b;
      in_valid  <= 1'b1;
      if (item.typed) begin
        pending.value = item.value;
        pending.cmp   = item.cmp;
        pending.dz    = item.dz;
      end else begin
        pending = predict_alu(item.mode, item.a, item.b);
      end
      do @(posedge clk); while (!in_ready);
      expected_q.push_back(pending);
      n_sent++;
      mode_seen[item.mode] = 1'b1;
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    foreach (mode_seen[i]) n_modes += mode_seen[i];
    $display("Sent %0d operations (%0d from the directed table) over %0d of 16 mode codes,",
             n_sent, directed_rows.size(), n_modes);
    $display("with random idling, a %0d-cycle output stall and %0d results checked.",
             PressureCycles, results_seen);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
